/* hw/rtl/tes_pkg.sv */
package tes_pkg;

  localparam int unsigned TES_QUEUE_DEPTH  = 64;
  localparam int unsigned TES_TIME_BITS    = 48;
  localparam int unsigned TES_MAX_RESULTS  = 64;
  localparam int unsigned TES_RUN_CNT_BITS = $clog2(TES_MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    FUNC_SCHEDULE  = 2'd0,
    FUNC_TICK      = 2'd1,
    FUNC_CLEAR     = 2'd2,
    FUNC_RESET_ALL = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [47:0] event_time;
    logic [1:0]  event_kind;
    logic [1:0]  port_number;
    logic [4:0]  channel_number;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
  } in_item_t;

  typedef struct packed {
    logic [47:0] out_time;
    logic [1:0]  out_kind;
    logic [1:0]  out_port;
    logic [4:0]  out_channel;
    logic [6:0]  out_first;
    logic [6:0]  out_second;
    logic        last_of_run;
    logic        overflow;
  } out_item_t;

  // Event payload as held in the queue
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] port;
    logic [4:0] channel;
    logic [6:0] first;
    logic [6:0] second;
  } payload_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic clr_q;
    logic clr_t;
    logic ins_init;
    logic ins_shift;
    logic ins_place;
    logic fl_init;
    logic fl_read;
    logic fl_take;
    logic fl_last;
    logic push_ovf;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_zero;
    logic later;
    logic have_entry;
    logic due;
    logic pend_v;
    logic slot_free;
  } status_t;

endpackage

/* hw/rtl/tes_ctrl.sv */
module tes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tes_pkg::func_t    in_func,
  output logic              in_ready,
  input  tes_pkg::status_t  st,
  output tes_pkg::cmd_t     cmd
);
  import tes_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS_SCAN = 6'b000010,
    S_OVF      = 6'b000100,
    S_FL_READ  = 6'b001000,
    S_FL_EVAL  = 6'b010000,
    S_FL_LAST  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_func)
            FUNC_SCHEDULE: begin
              if (st.full) begin
                state_nxt = S_OVF;
              end else begin
                cmd.ins_init = 1'b1;
                state_nxt    = S_INS_SCAN;
              end
            end
            FUNC_TICK: begin
              cmd.tick    = 1'b1;
              cmd.fl_init = 1'b1;
              state_nxt   = S_FL_READ;
            end
            FUNC_CLEAR: begin
              cmd.clr_q = 1'b1;
            end
            FUNC_RESET_ALL: begin
              cmd.clr_q = 1'b1;
              cmd.clr_t = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_INS_SCAN: begin
        // walk down from the tail while queued entries are strictly later
        if (!st.scan_zero && st.later) begin
          cmd.ins_shift = 1'b1;
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_OVF: begin
        if (st.slot_free) begin
          cmd.push_ovf = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FL_READ: begin
        if (st.have_entry) begin
          cmd.fl_read = 1'b1;
          state_nxt   = S_FL_EVAL;
        end else begin
          state_nxt = S_FL_LAST;
        end
      end
      S_FL_EVAL: begin
        if (st.due) begin
          if (!st.pend_v || st.slot_free) begin
            cmd.fl_take = 1'b1;
            state_nxt   = S_FL_READ;
          end
        end else begin
          state_nxt = S_FL_LAST;
        end
      end
      S_FL_LAST: begin
        if (!st.pend_v) begin
          state_nxt = S_IDLE;
        end else if (st.slot_free) begin
          cmd.fl_last = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/tes_dpath.sv */
module tes_dpath #(
  parameter int unsigned QUEUE_DEPTH = tes_pkg::TES_QUEUE_DEPTH,
  parameter int unsigned TIME_BITS   = tes_pkg::TES_TIME_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tes_pkg::in_item_t  in_data,
  input  tes_pkg::cmd_t      cmd,
  output tes_pkg::status_t   st,
  output logic               out_valid,
  input  logic               out_ready,
  output tes_pkg::out_item_t out_data
);
  import tes_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned NW = TES_RUN_CNT_BITS;
  localparam logic [63:0] TMAX64 = {64{1'b1}} >> (64 - TIME_BITS);
  localparam logic [TW-1:0] TMAX = TMAX64[TW-1:0];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  // queue storage
  logic [TW-1:0] time_mem [QUEUE_DEPTH];
  payload_t      pay_mem  [QUEUE_DEPTH];

  // control registers
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [TW-1:0] cur_time_r, cur_time_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  in_item_t      item_r;
  logic [TW-1:0] item_time_r;
  logic [TW-1:0] rd_time_r;
  payload_t      rd_pay_r;
  logic [TW-1:0] pend_time_r;
  payload_t      pend_pay_r;
  out_item_t     out_data_r, out_data_nxt;

  logic [63:0]   in_time_ext;
  logic [TW-1:0] in_time_clamped;
  logic [SW-1:0] tail_sum;
  logic [PW-1:0] tail_ptr;
  logic          rd_en;
  logic [PW-1:0] raddr;
  logic          we;
  logic [PW-1:0] waddr;
  logic [TW-1:0] wtime;
  payload_t      wpay;
  payload_t      item_pay;
  logic          push;
  logic [TW-1:0] push_time;
  payload_t      push_pay;
  logic [63:0]   push_time_ext;
  logic          slot_free;

  assign in_time_ext     = 64'(in_data.event_time);
  assign in_time_clamped = (in_time_ext > TMAX64) ? TMAX : in_time_ext[TW-1:0];

  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail_ptr = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : PW'(tail_sum);

  assign item_pay = '{kind:    item_r.event_kind,
                      port:    item_r.port_number,
                      channel: item_r.channel_number,
                      first:   item_r.first_data,
                      second:  item_r.second_data};

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    count_nxt    = count_r;
    head_nxt     = head_r;
    rd_ptr_nxt   = rd_ptr_r;
    scan_nxt     = scan_r;
    n_nxt        = n_r;
    cur_time_nxt = cur_time_r;
    pend_v_nxt   = pend_v_r;

    if (cmd.tick) begin
      cur_time_nxt = (cur_time_r == TMAX) ? cur_time_r : cur_time_r + 1'b1;
    end
    if (cmd.clr_t) begin
      cur_time_nxt = '0;
    end
    if (cmd.clr_q) begin
      count_nxt = '0;
    end
    if (cmd.ins_init) begin
      rd_ptr_nxt = ptr_dec(tail_ptr);
      scan_nxt   = count_r;
    end
    if (cmd.ins_shift) begin
      rd_ptr_nxt = ptr_dec(rd_ptr_r);
      scan_nxt   = scan_r - 1'b1;
    end
    if (cmd.ins_place) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.fl_init) begin
      n_nxt      = '0;
      pend_v_nxt = 1'b0;
    end
    if (cmd.fl_take) begin
      head_nxt   = ptr_inc(head_r);
      count_nxt  = count_r - 1'b1;
      n_nxt      = n_r + 1'b1;
      pend_v_nxt = 1'b1;
    end
    if (cmd.fl_last) begin
      pend_v_nxt = 1'b0;
    end
  end

  // memory ports
  assign rd_en = cmd.ins_init | cmd.ins_shift | cmd.fl_read;
  assign raddr = cmd.fl_read ? head_r : rd_ptr_nxt;
  assign we    = cmd.ins_shift | cmd.ins_place;
  assign waddr = ptr_inc(rd_ptr_r);
  assign wtime = cmd.ins_shift ? rd_time_r : item_time_r;
  assign wpay  = cmd.ins_shift ? rd_pay_r : item_pay;

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr] <= wtime;
      pay_mem[waddr]  <= wpay;
    end
    if (rd_en) begin
      rd_time_r <= time_mem[raddr];
      rd_pay_r  <= pay_mem[raddr];
    end
  end

  // result register
  assign push = cmd.push_ovf | cmd.fl_last | (cmd.fl_take & pend_v_r);

  always_comb begin
    if (cmd.push_ovf) begin
      push_time = item_time_r;
      push_pay  = item_pay;
    end else begin
      push_time = pend_time_r;
      push_pay  = pend_pay_r;
    end
    push_time_ext = 64'(push_time);
    out_data_nxt  = '{out_time:    push_time_ext[47:0],
                      out_kind:    push_pay.kind,
                      out_port:    push_pay.port,
                      out_channel: push_pay.channel,
                      out_first:   push_pay.first,
                      out_second:  push_pay.second,
                      last_of_run: cmd.push_ovf | cmd.fl_last,
                      overflow:    cmd.push_ovf};
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      rd_ptr_r    <= '0;
      scan_r      <= '0;
      n_r         <= '0;
      cur_time_r  <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      scan_r      <= scan_nxt;
      n_r         <= n_nxt;
      cur_time_r  <= cur_time_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r      <= in_data;
      item_time_r <= in_time_clamped;
    end
    if (cmd.fl_take) begin
      pend_time_r <= rd_time_r;
      pend_pay_r  <= rd_pay_r;
    end
    if (push) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign st = '{full:       (count_r == CW'(QUEUE_DEPTH)),
                scan_zero:  (scan_r == '0),
                later:      (rd_time_r > item_time_r),
                have_entry: (count_r != '0) && (n_r != NW'(TES_MAX_RESULTS)),
                due:        (rd_time_r <= cur_time_r),
                pend_v:     pend_v_r,
                slot_free:  slot_free};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/timed_event_scheduler.sv */
// Channel   | Ports                       | Transaction
// ----------+-----------------------------+------------------------------------
// input     | in_valid, in_ready, in_data | one command: schedule/tick/clear/reset all
// result    | out_valid, out_ready, out_data | one emitted or rejected event
//
// Clear and reset all complete in the cycle they are accepted. A schedule walks the
// insert down from the tail through the queue RAM, past every queued event strictly
// later than the new one, reading one entry and writing one a cycle. A tick reads
// and then checks one entry at a time until the queue is empty, the run reaches
// TES_MAX_RESULTS or an event is not yet due; a tick, like a rejected schedule, may
// wait on the result register.
// Reset: synchronous, active low; clears time and fill count, no RAM clearing pass.
// Stalls: one result register decouples out_ready; the controller waits on it.
module timed_event_scheduler #(
  parameter int unsigned QUEUE_DEPTH = tes_pkg::TES_QUEUE_DEPTH,
  parameter int unsigned TIME_BITS   = tes_pkg::TES_TIME_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tes_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tes_pkg::out_item_t out_data
);
  import tes_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Controller: sequences insert walk, flush loop and overflow report
  tes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: circular queue RAM (head pointer + fill count), time counter,
  // held-back flush entry for last_of_run lookahead, result register
  tes_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/tes_checker.sv */
module tes_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input tes_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input tes_pkg::out_item_t out_data
);
  import tes_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.last_of_run)
    else $error("overflow result not marked last");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_data.func == FUNC_SCHEDULE || in_data.func == FUNC_TICK) |=> !in_ready)
    else $error("schedule or tick did not occupy the block");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind timed_event_scheduler tes_checker u_tes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/timed_event_scheduler_tb.sv */
module timed_event_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tes_pkg::*;

  // Largest value the time counter can hold; it sticks here once reached.
  localparam logic [47:0] TIME_TOP = 48'((64'd1 << TES_TIME_BITS) - 64'd1);

  // Longest stretch without a transaction on either channel in a correct run:
  // a schedule walking past an almost full queue, a sender gap and a receiver
  // stall. The limit is many times that.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Quiet time after the last result: covers a schedule still walking the
  // queue, which produces nothing visible when it completes.
  localparam int unsigned DRAIN_CYCLES = 150;

  localparam int unsigned REPORT_LIMIT = 10;

  // Receiver behaviour, re-chosen at random span by span.
  typedef enum logic [1:0] {
    RX_FREE,    // always ready
    RX_COIN,    // ready on a coin toss
    RX_SPARSE   // ready at a random spacing picked per span
  } rx_mode_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  timed_event_scheduler u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler model: sorted queue of due times and payloads, plus the tick count
  // ---------------------------------------------------------------------------
  logic [47:0] model_time [TES_QUEUE_DEPTH];
  payload_t    model_event [TES_QUEUE_DEPTH];
  int unsigned model_fill = 0;
  logic [47:0] now_tick = '0;

  // Events the block still owes us, oldest first
  out_item_t awaited_events [$];

  int unsigned error_count = 0;

  function automatic void await_event(input out_item_t r);
    awaited_events.insert(awaited_events.size(), r);
  endfunction

  function automatic out_item_t make_result(input logic [47:0] t, input payload_t p,
                                            input logic last, input logic ovf);
    out_item_t r;
    r.out_time    = t;
    r.out_kind    = p.kind;
    r.out_port    = p.port;
    r.out_channel = p.channel;
    r.out_first   = p.first;
    r.out_second  = p.second;
    r.last_of_run = last;
    r.overflow    = ovf;
    return r;
  endfunction

  function automatic void predict_scheduler(input in_item_t cmd);
    logic [47:0] t;
    payload_t    p;
    int unsigned pos;
    int unsigned n;
    t         = cmd.event_time;
    p.kind    = cmd.event_kind;
    p.port    = cmd.port_number;
    p.channel = cmd.channel_number;
    p.first   = cmd.first_data;
    p.second  = cmd.second_data;
    case (cmd.func)
      FUNC_SCHEDULE: begin
        if (t > TIME_TOP) t = TIME_TOP;
        if (model_fill >= TES_QUEUE_DEPTH) begin
          // full: echo the rejected event as a one-result run
          await_event(make_result(t, p, 1'b1, 1'b1));
        end else begin
          // goes behind everything due at the same time or earlier
          pos = 0;
          while (pos < model_fill && model_time[pos] <= t) pos++;
          for (int i = model_fill; i > pos; i--) begin
            model_time[i]  = model_time[i-1];
            model_event[i] = model_event[i-1];
          end
          model_time[pos]  = t;
          model_event[pos] = p;
          model_fill++;
        end
      end
      FUNC_TICK: begin
        if (now_tick < TIME_TOP) now_tick++;
        n = 0;
        while (n < model_fill && n < TES_MAX_RESULTS && model_time[n] <= now_tick) n++;
        for (int i = 0; i < n; i++)
          await_event(make_result(model_time[i], model_event[i], (i + 1 == n), 1'b0));
        for (int i = 0; i + n < model_fill; i++) begin
          model_time[i]  = model_time[i+n];
          model_event[i] = model_event[i+n];
        end
        model_fill -= n;
      end
      FUNC_CLEAR: model_fill = 0;
      default: begin
        model_fill = 0;
        now_tick   = '0;
      end
    endcase
  endfunction

  function automatic void check_event(input out_item_t got);
    out_item_t want;
    if (awaited_events.size() == 0) begin
      if (error_count < REPORT_LIMIT)
        $display("unexpected event t=%h k=%0d p=%0d c=%0d d1=%0d d2=%0d l=%0b o=%0b",
                 got.out_time, got.out_kind, got.out_port, got.out_channel,
                 got.out_first, got.out_second, got.last_of_run, got.overflow);
      error_count++;
      return;
    end
    want = awaited_events.pop_front();
    if (got.out_time !== want.out_time || got.out_kind !== want.out_kind ||
        got.out_port !== want.out_port || got.out_channel !== want.out_channel ||
        got.out_first !== want.out_first || got.out_second !== want.out_second ||
        got.last_of_run !== want.last_of_run || got.overflow !== want.overflow) begin
      if (error_count < REPORT_LIMIT) begin
        $display("mismatch exp t=%h k=%0d p=%0d c=%0d d1=%0d d2=%0d l=%0b o=%0b",
                 want.out_time, want.out_kind, want.out_port, want.out_channel,
                 want.out_first, want.out_second, want.last_of_run, want.overflow);
        $display("         got t=%h k=%0d p=%0d c=%0d d1=%0d d2=%0d l=%0b o=%0b",
                 got.out_time, got.out_kind, got.out_port, got.out_channel,
                 got.out_first, got.out_second, got.last_of_run, got.overflow);
      end
      error_count++;
    end
  endfunction

  // Results are checked before the same edge's input transaction is modelled;
  // a result can never come from a command accepted at that very edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_event(out_data);
      if (in_valid && in_ready) predict_scheduler(in_data);
    end
  end

  // Watchdog: cycles without any transaction
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: back-pressure pattern, re-chosen every span of cycles
  initial begin
    rx_mode_t    mode;
    int unsigned span;
    int unsigned every;
    out_ready = 1'b0;
    forever begin
      mode  = rx_mode_t'($urandom_range(0, 2));
      span  = $urandom_range(16, 96);
      every = $urandom_range(2, 10);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          RX_FREE: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (c % every == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  bit          valid_held = 1'b0;

  // Called at a falling edge; returns at a falling edge after the transaction.
  // Valid stays up within a burst so back-to-back commands get through, and
  // drops for a random gap when the burst runs out.
  task automatic send_command(input in_item_t cmd);
    in_data    <= cmd;
    in_valid   <= 1'b1;
    valid_held = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_valid   <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  // Every field random; the block must ignore those a command does not use
  function automatic in_item_t random_item(input func_t f);
    in_item_t cmd;
    cmd.func           = f;
    cmd.event_time     = {16'($urandom), 32'($urandom)};
    cmd.event_kind     = 2'($urandom);
    cmd.port_number    = 2'($urandom);
    cmd.channel_number = 5'($urandom);
    cmd.first_data     = 7'($urandom);
    cmd.second_data    = 7'($urandom);
    return cmd;
  endfunction

  // Mostly near the current tick so events do fall due; some far off or at the ends
  function automatic logic [47:0] pick_time();
    int unsigned sel;
    int unsigned d;
    sel = $urandom_range(0, 99);
    d   = $urandom_range(0, 4);
    if (sel < 60) return now_tick + 48'(d);
    if (sel < 75) return (now_tick > 48'(d)) ? now_tick - 48'(d) : '0;
    if (sel < 90) return {16'($urandom), 32'($urandom)};
    return (sel < 95) ? '0 : TIME_TOP;
  endfunction

  task automatic schedule_event(input logic [47:0] t, input logic [1:0] kind,
                                input logic [1:0] port, input logic [4:0] chan,
                                input logic [6:0] d1, input logic [6:0] d2);
    in_item_t cmd;
    cmd                = random_item(FUNC_SCHEDULE);
    cmd.event_time     = t;
    cmd.event_kind     = kind;
    cmd.port_number    = port;
    cmd.channel_number = chan;
    cmd.first_data     = d1;
    cmd.second_data    = d2;
    send_command(cmd);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Sort order, equal-time arrival order, field extremes, odd payloads,
  // empty tick. Time starts at zero.
  task automatic test_ordering_and_extremes();
    schedule_event(48'd2, 2'd0, 2'd1, 5'd1, 7'd0, 7'd127);
    schedule_event(48'd1, 2'd1, 2'd2, 5'd16, 7'd127, 7'd0);
    schedule_event(48'd2, 2'd2, 2'd0, 5'd0, 7'd64, 7'd1);     // odd port and channel
    schedule_event(48'd0, 2'd3, 2'd3, 5'd31, 7'd127, 7'd127); // already due at time zero
    schedule_event(TIME_TOP, 2'd0, 2'd1, 5'd9, 7'd60, 7'd100);
    schedule_event(48'h5555_5555_5555, 2'd1, 2'd2, 5'd10, 7'h2a, 7'h55);
    send_command(random_item(FUNC_TICK));  // time 1: the 0 and 1 events
    send_command(random_item(FUNC_TICK));  // time 2: both time-2 events, arrival order
    send_command(random_item(FUNC_TICK));  // time 3: nothing due
  endtask

  // Clear drops the queue; reset all drops it and rewinds time to zero
  task automatic test_clear_and_reset_all();
    schedule_event(48'd4, 2'd2, 2'd1, 5'd3, 7'd7, 7'd70);
    send_command(random_item(FUNC_CLEAR));
    send_command(random_item(FUNC_TICK));  // time 4: queue empty, nothing out
    schedule_event(48'd5, 2'd0, 2'd2, 5'd4, 7'd11, 7'd22);
    send_command(random_item(FUNC_RESET_ALL));
    schedule_event(48'd2, 2'd1, 2'd1, 5'd5, 7'd33, 7'd44);
    send_command(random_item(FUNC_TICK));  // time 1: not yet due
    send_command(random_item(FUNC_TICK));  // time 2: due now
    send_command(random_item(FUNC_TICK));
  endtask

  // Fill to the brim with events due at the next tick, push past it for
  // overflow echoes, then flush the lot in one long run
  task automatic test_full_queue();
    in_item_t cmd;
    send_command(random_item(FUNC_CLEAR));
    for (int i = 0; i < TES_QUEUE_DEPTH; i++) begin
      cmd            = random_item(FUNC_SCHEDULE);
      cmd.event_time = now_tick + 48'($urandom_range(0, 1));
      send_command(cmd);
    end
    for (int i = 0; i < 3; i++) begin
      cmd            = random_item(FUNC_SCHEDULE);
      cmd.event_time = pick_time();
      send_command(cmd);
    end
    send_command(random_item(FUNC_TICK));
    send_command(random_item(FUNC_TICK));
  endtask

  // Mixed traffic; clears and resets now and then keep far-off events from
  // piling up for good, though the queue may still fill on occasion
  task automatic test_random_traffic();
    in_item_t    cmd;
    int unsigned sel;
    for (int k = 0; k < 72; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        cmd            = random_item(FUNC_SCHEDULE);
        cmd.event_time = pick_time();
        send_command(cmd);
      end else if (sel < 90) begin
        send_command(random_item(FUNC_TICK));
      end else if (sel < 95) begin
        send_command(random_item(FUNC_CLEAR));
      end else begin
        send_command(random_item(FUNC_RESET_ALL));
      end
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ordering_and_extremes();
    test_clear_and_reset_all();
    test_full_queue();
    test_random_traffic();

    if (valid_held) in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
